@@ sv/pts_pkg.sv @@
// Shared constants for the pass temperature statistics block.
package pts_pkg;

  localparam int TEMP_W = 12;
  localparam int ERR_W  = 13;
  localparam int CFG_IDX_W = 1;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int MAX_PASSES_DEF  = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT       = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DROP_THRESHOLD = 1'd1;

  localparam logic [TEMP_W-1:0] SETPOINT_RST       = 12'd2100;
  localparam logic [TEMP_W-1:0] DROP_THRESHOLD_RST = 12'd50;

endpackage

@@ sv/pass_temperature_stats.sv @@
// Top level: pass accumulation with a bit-serial divider for the pass average.
//
// Input channel (in_valid / in_stall) carries one temperature sample and the
// plates_closed flag per transaction. Closed samples accumulate sum, count and
// peak, up to MAX_SAMPLES, and never produce a result. The first open sample
// after a pass ends the pass and yields one result on the output channel
// (out_valid / out_stall); open samples outside a pass are dropped.
// Ending a pass runs a restoring divider that retires one quotient bit per
// cycle over the full sum width, 12 + clog2(MAX_SAMPLES+1) bits, and then
// finishes the result in S_DONE, so the end-of-pass sample holds the input
// channel until the result is loaded; closed samples do not stall it.
// The result sits in an output register: while the receiver stalls, further
// closed samples are still taken, and only a new pass end waits for the slot.
// Configuration writes (cfg_write, cfg_index, cfg_data) are registered.
// Reset (rst, synchronous) restores register defaults, clears the pass state,
// the valid-pass count and the held error, and empties the output register.
module pass_temperature_stats #(
  parameter int MAX_SAMPLES = pts_pkg::MAX_SAMPLES_DEF,
  parameter int MAX_PASSES  = pts_pkg::MAX_PASSES_DEF,
  parameter int PASS_W      = $clog2(MAX_PASSES + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [pts_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pts_pkg::TEMP_W-1:0]  cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [pts_pkg::TEMP_W-1:0]  temperature,
  input  logic                        plates_closed,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        pass_valid,
  output logic [pts_pkg::TEMP_W-1:0]  average_temp,
  output logic [pts_pkg::TEMP_W-1:0]  pass_peak,
  output logic signed [pts_pkg::ERR_W-1:0] temp_error,
  output logic [PASS_W-1:0]           valid_passes
);
  import pts_pkg::*;

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = TEMP_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} state_t;

  state_t state;

  logic [TEMP_W-1:0] setpoint;
  logic [TEMP_W-1:0] drop_threshold;

  logic              in_pass;
  logic [SUM_W-1:0]  sample_sum;
  logic [CNT_W-1:0]  sample_count;
  logic [TEMP_W-1:0] peak_temp;
  logic [PASS_W-1:0] valid_pass_count;
  logic signed [ERR_W-1:0] held_error;

  logic [SUM_W-1:0]  div_sum;
  logic [CNT_W-1:0]  div_rem;
  logic [TEMP_W-1:0] quot;
  logic [STEP_W-1:0] step;

  logic              in_take;
  logic              out_free;
  logic [CNT_W:0]    rem_shift;
  logic              rem_ge;
  logic [CNT_W:0]    rem_diff;
  logic [TEMP_W-1:0] avg;
  logic [ERR_W-1:0]  drop;
  logic              valid_now;
  logic signed [ERR_W-1:0] err_now;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // one restoring-division step: shift in the next sum bit, try subtracting
  assign rem_shift = {div_rem, div_sum[SUM_W-1]};
  assign rem_ge    = (rem_shift >= {1'b0, sample_count});
  assign rem_diff  = rem_shift - {1'b0, sample_count};

  assign avg       = (sample_count == '0) ? '0 : quot;
  assign drop      = {1'b0, peak_temp} - {1'b0, avg};
  assign valid_now = !drop[ERR_W-1] && (drop[TEMP_W-1:0] >= drop_threshold);
  assign err_now   = $signed({1'b0, setpoint}) - $signed({1'b0, avg});

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      setpoint         <= SETPOINT_RST;
      drop_threshold   <= DROP_THRESHOLD_RST;
      in_pass          <= 1'b0;
      sample_sum       <= '0;
      sample_count     <= '0;
      peak_temp        <= '0;
      valid_pass_count <= '0;
      held_error       <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          CFG_SETPOINT:       setpoint       <= cfg_data;
          CFG_DROP_THRESHOLD: drop_threshold <= cfg_data;
          default: ;
        endcase
      end

      // drop the taken result unless a new one is loaded this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_take) begin
            if (plates_closed) begin
              if (!in_pass) begin
                in_pass      <= 1'b1;
                sample_sum   <= SUM_W'(temperature);
                sample_count <= CNT_W'(1);
                peak_temp    <= temperature;
              end else if (sample_count < CNT_W'(MAX_SAMPLES)) begin
                sample_sum   <= sample_sum + SUM_W'(temperature);
                sample_count <= sample_count + CNT_W'(1);
                if (temperature > peak_temp) begin
                  peak_temp <= temperature;
                end
              end
            end else if (in_pass) begin
              // end of pass: start the divider on the frozen sum
              in_pass <= 1'b0;
              div_sum <= sample_sum;
              div_rem <= '0;
              quot    <= '0;
              step    <= STEP_W'(SUM_W - 1);
              state   <= S_DIV;
            end
          end
        end
        S_DIV: begin
          div_sum <= {div_sum[SUM_W-2:0], 1'b0};
          div_rem <= rem_ge ? rem_diff[CNT_W-1:0] : rem_shift[CNT_W-1:0];
          quot    <= {quot[TEMP_W-2:0], rem_ge};
          step    <= step - STEP_W'(1);
          if (step == '0) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            pass_valid   <= valid_now;
            average_temp <= avg;
            pass_peak    <= peak_temp;
            if (valid_now) begin
              held_error <= err_now;
              temp_error <= err_now;
              if (valid_pass_count != PASS_W'(MAX_PASSES)) begin
                valid_pass_count <= valid_pass_count + PASS_W'(1);
                valid_passes     <= valid_pass_count + PASS_W'(1);
              end else begin
                valid_passes <= valid_pass_count;
              end
            end else begin
              temp_error   <= held_error;
              valid_passes <= valid_pass_count;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// Testbench for the pass temperature statistics block: directed rows, then random passes.
`timescale 1ns / 100ps

module testbench;
  import pts_pkg::*;

  localparam int PASS_W = $clog2(MAX_PASSES_DEF + 1);
  localparam int NUM_PHASES = 6;
  localparam int NUM_ROWS = 25;
  localparam int LONG_PASS_PHASE = 2;
  localparam int ITEMS_PER_PHASE = 130;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic                     pass_valid;
    logic [TEMP_W-1:0]        average_temp;
    logic [TEMP_W-1:0]        pass_peak;
    logic signed [ERR_W-1:0]  temp_error;
    logic [PASS_W-1:0]        valid_passes;
  } pass_summary_t;

  typedef struct {
    logic [TEMP_W-1:0] temp;
    logic              closed;
    bit                typed;
    pass_summary_t     want;
  } stim_row_t;

  typedef struct {
    logic [TEMP_W-1:0] target;
    logic [TEMP_W-1:0] min_drop;
    int                idle_pct;
    int                stall_pct;
  } phase_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index = CFG_SETPOINT;
  logic [TEMP_W-1:0]       cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [TEMP_W-1:0]       temperature = '0;
  logic                    plates_closed = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    pass_valid;
  logic [TEMP_W-1:0]       average_temp;
  logic [TEMP_W-1:0]       pass_peak;
  logic signed [ERR_W-1:0] temp_error;
  logic [PASS_W-1:0]       valid_passes;

  pass_temperature_stats dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .temperature(temperature), .plates_closed(plates_closed),
    .out_valid(out_valid), .out_stall(out_stall),
    .pass_valid(pass_valid), .average_temp(average_temp), .pass_peak(pass_peak),
    .temp_error(temp_error), .valid_passes(valid_passes)
  );

  always #5 clk = ~clk;

  // Pass accumulator mirror and register copies
  bit                acc_in_pass;
  int unsigned       acc_sum;
  int unsigned       acc_count;
  int unsigned       acc_peak;
  int unsigned       valid_pass_total;
  int                held_temp_error;
  logic [TEMP_W-1:0] reg_target = SETPOINT_RST;
  logic [TEMP_W-1:0] reg_min_drop = DROP_THRESHOLD_RST;

  pass_summary_t pass_summaries[$];
  int            mismatch_count = 0;
  int            idle_pct = 0;
  int            stall_pct = 0;

  stim_row_t directed_rows [NUM_ROWS] = '{
    '{12'd123,  1'b0, 1'b0, '0},
    '{12'd4095, 1'b1, 1'b0, '0},
    '{12'd0,    1'b1, 1'b0, '0},
    '{12'd777,  1'b0, 1'b1, '{1'b1, 12'd2047, 12'd4095, 13'sd53, 5'd1}},
    '{12'd0,    1'b1, 1'b0, '0},
    '{12'd0,    1'b0, 1'b1, '{1'b0, 12'd0, 12'd0, 13'sd53, 5'd1}},
    '{12'd4095, 1'b1, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b1, '{1'b0, 12'd4095, 12'd4095, 13'sd53, 5'd1}},
    '{12'd100,  1'b1, 1'b0, '0},
    '{12'd0,    1'b1, 1'b0, '0},
    '{12'd0,    1'b0, 1'b1, '{1'b1, 12'd50, 12'd100, 13'sd2050, 5'd2}},
    '{12'd98,   1'b1, 1'b0, '0},
    '{12'd0,    1'b1, 1'b0, '0},
    '{12'd0,    1'b0, 1'b1, '{1'b0, 12'd49, 12'd98, 13'sd2050, 5'd2}},
    '{12'd4095, 1'b1, 1'b0, '0},
    '{12'd4094, 1'b1, 1'b0, '0},
    '{12'd4094, 1'b1, 1'b0, '0},
    '{12'd4095, 1'b0, 1'b1, '{1'b0, 12'd4094, 12'd4095, 13'sd2050, 5'd2}},
    '{12'd1,    1'b1, 1'b0, '0},
    '{12'd2,    1'b1, 1'b0, '0},
    '{12'd2000, 1'b1, 1'b0, '0},
    '{12'd0,    1'b0, 1'b0, '0},
    '{12'hAAA,  1'b1, 1'b0, '0},
    '{12'h555,  1'b1, 1'b0, '0},
    '{12'hFFF,  1'b0, 1'b0, '0}
  };

  phase_t phases [NUM_PHASES] = '{
    '{12'd0,    12'd0,    0,  0},
    '{12'd4095, 12'd4095, 65, 0},
    '{12'd2100, 12'd50,   0,  65},
    '{12'd4095, 12'd0,    29, 29},
    '{12'd2048, 12'd1000, 0,  0},
    '{12'd1234, 12'd1,    29, 29}
  };

  function automatic void track_pass_sample(input logic [TEMP_W-1:0] t, input logic closed,
                                            output bit produced, output pass_summary_t summary);
    int unsigned avg;
    bit          good;
    produced = 1'b0;
    summary = '0;
    if (closed) begin
      if (!acc_in_pass) begin
        acc_in_pass = 1'b1;
        acc_sum = 0;
        acc_count = 0;
        acc_peak = t;
      end
      // drop samples beyond the limit
      if (acc_count < MAX_SAMPLES_DEF) begin
        acc_sum += t;
        acc_count++;
        if (t > acc_peak) acc_peak = t;
      end
    end else if (acc_in_pass) begin
      avg = (acc_count != 0) ? acc_sum / acc_count : 0;
      good = (acc_peak >= avg) && (acc_peak - avg >= reg_min_drop);
      if (good) begin
        held_temp_error = int'(reg_target) - int'(avg);
        if (valid_pass_total < MAX_PASSES_DEF) valid_pass_total++;
      end
      summary.pass_valid = good;
      summary.average_temp = avg[TEMP_W-1:0];
      summary.pass_peak = acc_peak[TEMP_W-1:0];
      summary.temp_error = held_temp_error[ERR_W-1:0];
      summary.valid_passes = valid_pass_total[PASS_W-1:0];
      produced = 1'b1;
      acc_in_pass = 1'b0;
      acc_sum = 0;
      acc_count = 0;
      acc_peak = 0;
    end
  endfunction

  task automatic send_sample(input logic [TEMP_W-1:0] t, input logic closed);
    bit            produced;
    pass_summary_t summary;
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    temperature <= t;
    plates_closed <= closed;
    do @(posedge clk); while (in_stall);
    track_pass_sample(t, closed, produced, summary);
    if (produced) pass_summaries.push_back(summary);
  endtask

  task automatic send_pass(input int len, input int style);
    int base;
    int v;
    base = $urandom_range(0, 4095);
    for (int i = 0; i < len; i++) begin
      case (style)
        0: v = $urandom_range(0, 4095);
        1: begin
          // cluster around a level so the drop lands near the threshold
          v = base + int'($urandom_range(0, 160)) - 80;
          if (v < 0) v = 0;
          if (v > 4095) v = 4095;
        end
        default: v = $urandom_range(0, 1) ? 4095 : 0;
      endcase
      send_sample(v[TEMP_W-1:0], 1'b1);
    end
    send_sample(TEMP_W'($urandom_range(0, 4095)), 1'b0);
  endtask

  task automatic load_registers(input logic [TEMP_W-1:0] target, input logic [TEMP_W-1:0] drop);
    cfg_write <= 1'b1;
    cfg_index <= CFG_SETPOINT;
    cfg_data <= target;
    @(posedge clk);
    cfg_index <= CFG_DROP_THRESHOLD;
    cfg_data <= drop;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_target = target;
    reg_min_drop = drop;
  endtask

  // Close any open pass, then wait until every pass result is back and the divider is quiet.
  task automatic finish_phase();
    if (acc_in_pass) send_sample(TEMP_W'($urandom_range(0, 4095)), 1'b0);
    in_valid <= 1'b0;
    while (pass_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic signed [13:0] want,
                             input logic signed [13:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    pass_summary_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pass_summaries.size() == 0) begin
        $error("pass result with no pass pending");
        mismatch_count++;
      end else begin
        want = pass_summaries.pop_front();
        check_field("pass_valid", want.pass_valid, pass_valid);
        check_field("average_temp", want.average_temp, average_temp);
        check_field("pass_peak", want.pass_peak, pass_peak);
        check_field("temp_error", $signed(want.temp_error), temp_error);
        check_field("valid_passes", want.valid_passes, valid_passes);
      end
    end
  end

  initial begin
    int sent;
    int len;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed rows run on the reset register values.
    for (int r = 0; r < NUM_ROWS; r++) begin
      send_sample(directed_rows[r].temp, directed_rows[r].closed);
      if (directed_rows[r].typed) pass_summaries[pass_summaries.size() - 1] = directed_rows[r].want;
    end
    finish_phase();

    for (int p = 0; p < NUM_PHASES; p++) begin
      load_registers(phases[p].target, phases[p].min_drop);
      idle_pct = phases[p].idle_pct;
      stall_pct = phases[p].stall_pct;
      // one-sample pass far from the target; only a zero threshold lets it set the error
      send_sample((phases[p].target == 0) ? 12'd4095 : 12'd0, 1'b1);
      send_sample(TEMP_W'($urandom_range(0, 4095)), 1'b0);
      if (p == LONG_PASS_PHASE) send_pass(MAX_SAMPLES_DEF + $urandom_range(1, 24), 0);
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) send_sample(TEMP_W'($urandom_range(0, 4095)), 1'b0);
        len = $urandom_range(1, 12);
        send_pass(len, $urandom_range(0, 2));
        sent += len + 1;
      end
      finish_phase();
    end

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ files.f @@
sv/pts_pkg.sv
sv/pass_temperature_stats.sv
tb/sv/testbench.sv
